// ===== rtl/volume_mute_and_calibration_tick_top_macros.svh =====
// assertion helpers for the checker of this block
`ifndef VOLUME_MUTE_AND_CALIBRATION_TICK_TOP_MACROS_SVH
`define VOLUME_MUTE_AND_CALIBRATION_TICK_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define VMCT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define VMCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/vmct_pkg.sv =====
`default_nettype none

package vmct_pkg;

  // mute machine codes
  localparam logic [2:0] ST_MUTE         = 3'd0;
  localparam logic [2:0] ST_READY        = 3'd1;
  localparam logic [2:0] ST_LOUD         = 3'd2;
  localparam logic [2:0] ST_PREHEAR      = 3'd3;
  localparam logic [2:0] ST_PREHEAR_LOUD = 3'd4;

  // beep codes
  localparam logic [1:0] BEEP_NONE  = 2'd0;
  localparam logic [1:0] BEEP_START = 2'd1;
  localparam logic [1:0] BEEP_STEP  = 2'd2;
  localparam logic [1:0] BEEP_END   = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_AUTOMUTE_EN   = 3'd0;
  localparam logic [2:0] CFG_AUTOPREHEAR   = 3'd1;
  localparam logic [2:0] CFG_LOW_PITCH     = 3'd2;
  localparam logic [2:0] CFG_HIGH_PITCH    = 3'd3;
  localparam logic [2:0] CFG_PREHEAR_LOUD  = 3'd4;

  // port widths
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 23;

  // result field positions in m_tdata
  localparam int OUT_MUTE_LSB   = 0;
  localparam int OUT_BEEP_LSB   = 3;
  localparam int OUT_CAPV_BIT   = 5;
  localparam int OUT_CM_LSB     = 6;
  localparam int OUT_VALUE_LSB  = 11;
  localparam int OUT_SAVE_BIT   = 43;
  localparam int OUT_ACTIVE_BIT = 44;

  // sequencer defaults
  localparam int DEF_CAL_STEPS     = 20;
  localparam int DEF_START_DELAY   = 8000;
  localparam int DEF_START_BEEP_AT = 7000;
  localparam int DEF_STEP_DELAY    = 4000;
  localparam int DEF_END_DELAY     = 1000;

  // register reset values
  localparam logic [15:0] RST_LOW_PITCH    = 16'd328;
  localparam logic [15:0] RST_HIGH_PITCH   = 16'd32113;
  localparam logic [22:0] RST_PREHEAR_LOUD = 23'd100;

endpackage

`default_nettype wire

// ===== rtl/volume_mute_and_calibration_tick_top.sv =====
// volume mute and calibration tick block
// input stream: one transaction per millisecond tick or calibration start;
//   s_tuser is the command (0 tick, 1 start calibration), s_tdata carries
//   pitch frequency, signed raw volume and the oscillator mean period
// output stream: exactly one result transaction per input transaction,
//   in order, with mute state, beep code, captured entry, save pulse and
//   the calibration active flag
// the result is registered: it shows on m_tvalid in the cycle after the input
//   transaction is accepted
// throughput: one transaction per cycle while results are taken; the whole update
//   is one pass of compare and decrement logic into a single result register
// when the receiver stalls, the result register holds and s_tready drops
//   until the result is taken; s_tready is high in the cycle it is taken
// configuration: cfg_wen with cfg_addr and cfg_wdata writes one register
//   in a cycle; write only while no result is pending
// reset (rst, synchronous): mute state, sequencer idle, registers to their
//   defaults (auto-mute off, so the first tick forces loud), no result
//   pending
`default_nettype none

module volume_mute_and_calibration_tick_top #(
  parameter int CAL_STEPS     = vmct_pkg::DEF_CAL_STEPS,
  parameter int START_DELAY   = vmct_pkg::DEF_START_DELAY,
  parameter int START_BEEP_AT = vmct_pkg::DEF_START_BEEP_AT,
  parameter int STEP_DELAY    = vmct_pkg::DEF_STEP_DELAY,
  parameter int END_DELAY     = vmct_pkg::DEF_END_DELAY
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // pitch_freq[15:0], volume_raw[39:16], mean_period[71:40]
  input  wire logic [vmct_pkg::IN_TDATA_W-1:0]   s_tdata,
  // cmd
  input  wire logic                              s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // mute_state[2:0], beep_code[4:3], capture_valid[5], capture_cm[10:6],
  // capture_value[42:11], save_and_unmute[43], calibration_active[44], zero
  output logic [vmct_pkg::OUT_TDATA_W-1:0]       m_tdata,
  input  wire logic                              cfg_wen,
  input  wire logic [vmct_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [vmct_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import vmct_pkg::*;

  // configuration registers
  logic        automute_enable;
  logic        autoprehear_enable;
  logic [15:0] low_pitch_threshold;
  logic [15:0] high_pitch_threshold;
  logic [22:0] prehear_loud_threshold;

  // block state
  logic [2:0]         mute_fsm;
  logic [2:0]         mute_fsm_next;
  logic               cal_active;
  logic               cal_active_next;
  logic [13:0]        cal_delay;
  logic [13:0]        cal_delay_next;
  logic signed [5:0]  cal_step;
  logic signed [5:0]  cal_step_next;

  // result fields
  logic [1:0]  beep;
  logic        cap_valid;
  logic [4:0]  cap_cm;
  logic [31:0] cap_value;
  logic        save;

  // input fields
  logic               cmd;
  logic [15:0]        pitch;
  logic signed [23:0] vol;
  logic [31:0]        period;

  logic accept;
  logic above_low;
  logic below_low;
  logic above_high;
  logic vol_zero;
  logic vol_pos;
  logic vol_above_thr;
  logic [13:0]       delay_dec;
  logic signed [5:0] step_dec;

  assign cmd    = s_tuser;
  assign pitch  = s_tdata[15:0];
  assign vol    = s_tdata[39:16];
  assign period = s_tdata[71:40];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      automute_enable        <= 1'b0;
      autoprehear_enable     <= 1'b0;
      low_pitch_threshold    <= RST_LOW_PITCH;
      high_pitch_threshold   <= RST_HIGH_PITCH;
      prehear_loud_threshold <= RST_PREHEAR_LOUD;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        CFG_AUTOMUTE_EN:  automute_enable        <= cfg_wdata[0];
        CFG_AUTOPREHEAR:  autoprehear_enable     <= cfg_wdata[0];
        CFG_LOW_PITCH:    low_pitch_threshold    <= cfg_wdata[15:0];
        CFG_HIGH_PITCH:   high_pitch_threshold   <= cfg_wdata[15:0];
        CFG_PREHEAR_LOUD: prehear_loud_threshold <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // threshold compares
  assign above_low     = pitch > low_pitch_threshold;
  assign below_low     = pitch < low_pitch_threshold;
  assign above_high    = pitch > high_pitch_threshold;
  assign vol_zero      = vol == 24'sd0;
  assign vol_pos       = !vol[23] && !vol_zero;
  assign vol_above_thr = vol > $signed({1'b0, prehear_loud_threshold});

  // mute machine
  always_comb begin
    mute_fsm_next = mute_fsm;
    if (!automute_enable) begin
      mute_fsm_next = ST_LOUD;
    end else begin
      unique case (mute_fsm)
        ST_MUTE: begin
          if (above_low && vol_zero) mute_fsm_next = ST_READY;
        end
        ST_READY: begin
          if (above_high && vol_zero && autoprehear_enable) mute_fsm_next = ST_PREHEAR;
          if (above_low && vol_pos) mute_fsm_next = ST_LOUD;
        end
        ST_LOUD: begin
          if (below_low && vol_zero) mute_fsm_next = ST_MUTE;
        end
        ST_PREHEAR: begin
          if (above_low && vol_above_thr) mute_fsm_next = ST_PREHEAR_LOUD;
        end
        ST_PREHEAR_LOUD: begin
          if (above_low && vol_zero) mute_fsm_next = ST_LOUD;
        end
        default: ;
      endcase
    end
  end

  // calibration sequencer
  assign delay_dec = (cal_delay != 14'd0) ? cal_delay - 14'd1 : 14'd0;
  assign step_dec  = cal_step - 6'sd1;

  always_comb begin
    cal_active_next = cal_active;
    cal_delay_next  = cal_delay;
    cal_step_next   = cal_step;
    beep            = BEEP_NONE;
    cap_valid       = 1'b0;
    cap_cm          = 5'd0;
    cap_value       = 32'd0;
    save            = 1'b0;
    if (cal_active) begin
      cal_delay_next = delay_dec;
      if (delay_dec == 14'(START_BEEP_AT) && cal_step == 6'(CAL_STEPS)) beep = BEEP_START;
      if (delay_dec == 14'd0) begin
        cal_delay_next = 14'(STEP_DELAY);
        if (!cal_step[5]) begin
          cap_valid = 1'b1;
          cap_cm    = cal_step[4:0];
          cap_value = period;
        end
        cal_step_next = step_dec;
        if (!step_dec[5]) begin
          beep = BEEP_STEP;
        end else if (step_dec == -6'sd1) begin
          beep           = BEEP_END;
          cal_delay_next = 14'(END_DELAY);
        end else begin
          cal_step_next   = -6'sd2;
          cal_active_next = 1'b0;
          save            = 1'b1;
        end
      end
    end
  end

  // state update per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      mute_fsm   <= ST_MUTE;
      cal_active <= 1'b0;
      cal_delay  <= 14'd0;
      cal_step   <= 6'sd0;
    end else if (accept) begin
      if (cmd) begin
        cal_active <= 1'b1;
        cal_delay  <= 14'(START_DELAY);
        cal_step   <= 6'(CAL_STEPS);
      end else begin
        mute_fsm   <= mute_fsm_next;
        cal_active <= cal_active_next;
        cal_delay  <= cal_delay_next;
        cal_step   <= cal_step_next;
      end
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      if (cmd) begin
        m_tdata <= {3'd0, 1'b1, 1'b0, 32'd0, 5'd0, 1'b0, BEEP_NONE, mute_fsm};
      end else begin
        m_tdata <= {3'd0, cal_active_next, save, cap_value, cap_cm, cap_valid, beep,
                    mute_fsm_next};
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vmct_checker.sv =====
`default_nettype none
`include "volume_mute_and_calibration_tick_top_macros.svh"

module vmct_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tvalid,
  input wire logic                              s_tready,
  input wire logic [vmct_pkg::IN_TDATA_W-1:0]   s_tdata,
  input wire logic                              s_tuser,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [vmct_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input wire logic                              cfg_wen,
  input wire logic [vmct_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input wire logic [vmct_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import vmct_pkg::*;

  logic [2:0]  out_mute;
  logic [1:0]  out_beep;
  logic        out_capv;
  logic [4:0]  out_cm;
  logic [31:0] out_value;
  logic        out_save;
  logic        out_active;
  logic        unused_ok;

  assign out_mute   = m_tdata[OUT_MUTE_LSB +: 3];
  assign out_beep   = m_tdata[OUT_BEEP_LSB +: 2];
  assign out_capv   = m_tdata[OUT_CAPV_BIT];
  assign out_cm     = m_tdata[OUT_CM_LSB +: 5];
  assign out_value  = m_tdata[OUT_VALUE_LSB +: 32];
  assign out_save   = m_tdata[OUT_SAVE_BIT];
  assign out_active = m_tdata[OUT_ACTIVE_BIT];
  assign unused_ok  = s_tvalid ^ s_tready ^ s_tuser ^ (^s_tdata) ^ cfg_wen ^
                      (^cfg_addr) ^ (^cfg_wdata);

  // a stalled result holds
  `VMCT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // mute state stays within its five codes
  `VMCT_ASSERT_SAME(a_mute_range, m_tvalid, out_mute <= ST_PREHEAR_LOUD, "mute state out of range")

  // capture fields are zero without a capture
  `VMCT_ASSERT_SAME(a_cap_zero, m_tvalid && !out_capv, out_cm == 5'd0 && out_value == 32'd0, "capture fields set without capture")

  // a capture only happens while calibration runs on
  `VMCT_ASSERT_SAME(a_cap_active, m_tvalid && out_capv, out_active, "capture outside calibration")

  // the save pulse ends calibration and carries no beep or capture
  `VMCT_ASSERT_SAME(a_save_end, m_tvalid && out_save, !out_active && out_beep == BEEP_NONE && !out_capv, "save pulse with calibration still running")

endmodule

bind volume_mute_and_calibration_tick_top vmct_checker u_vmct_checker (.*);

`default_nettype wire

// ===== tb/volume_mute_and_calibration_tick_top_tb.sv =====
module volume_mute_and_calibration_tick_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vmct_pkg::*;

  localparam int CAL_STEPS     = DEF_CAL_STEPS;
  localparam int START_DELAY   = DEF_START_DELAY;
  localparam int START_BEEP_AT = DEF_START_BEEP_AT;
  localparam int STEP_DELAY    = DEF_STEP_DELAY;
  localparam int END_DELAY     = DEF_END_DELAY;
  localparam int CYCLE_LIMIT   = 1_000_000;

  typedef struct packed {
    logic [2:0]  mute;
    logic [1:0]  beep;
    logic        cap_valid;
    logic [4:0]  cap_cm;
    logic [31:0] cap_value;
    logic        save;
    logic        active;
  } tick_result_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_wen = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // expected results in issue order
  tick_result_t tick_results_q[$];
  int           err_count = 0;
  int           cycle_count = 0;
  bit           no_idle = 1'b0;

  // predictor copy of the registers
  logic        cfg_automute;
  logic        cfg_prehear;
  logic [15:0] cfg_low;
  logic [15:0] cfg_high;
  logic [22:0] cfg_thr;

  // predictor copy of the block state
  logic [2:0]  mute_st;
  bit          cal_run;
  int          cal_left;
  int          cal_idx;

  volume_mute_and_calibration_tick_top uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // receiver stalls
  always @(posedge clk) begin
    m_tready <= no_idle || ($urandom_range(99) >= 11);
  end

  // mute machine plus calibration sequencer, one transaction at a time
  function automatic tick_result_t predict_tick_result(input logic cmd,
                                                       input logic [15:0] pitch,
                                                       input logic [23:0] vol,
                                                       input logic [31:0] period);
    tick_result_t r;
    int           vol_i;
    bit           above_low;
    bit           below_low;
    bit           above_high;
    r = '0;
    vol_i = $signed(vol);
    above_low = pitch > cfg_low;
    below_low = pitch < cfg_low;
    above_high = pitch > cfg_high;
    if (cmd) begin
      cal_idx = CAL_STEPS;
      cal_left = START_DELAY;
      cal_run = 1'b1;
    end else begin
      // mute machine, held loud when auto-mute is off
      if (!cfg_automute) begin
        mute_st = ST_LOUD;
      end else begin
        case (mute_st)
          ST_MUTE: begin
            if (above_low && vol_i == 0) mute_st = ST_READY;
          end
          ST_READY: begin
            if (above_high && vol_i == 0 && cfg_prehear) mute_st = ST_PREHEAR;
            if (above_low && vol_i > 0) mute_st = ST_LOUD;
          end
          ST_LOUD: begin
            if (below_low && vol_i == 0) mute_st = ST_MUTE;
          end
          ST_PREHEAR: begin
            if (above_low && vol_i > int'(cfg_thr)) mute_st = ST_PREHEAR_LOUD;
          end
          ST_PREHEAR_LOUD: begin
            if (above_low && vol_i == 0) mute_st = ST_LOUD;
          end
          default: ;
        endcase
      end
      // calibration countdown and capture
      if (cal_run) begin
        if (cal_left > 0) cal_left--;
        if (cal_left == START_BEEP_AT && cal_idx == CAL_STEPS) r.beep = BEEP_START;
        if (cal_left <= 0) begin
          cal_left = STEP_DELAY;
          if (cal_idx >= 0) begin
            r.cap_valid = 1'b1;
            r.cap_cm = cal_idx[4:0];
            r.cap_value = period;
          end
          cal_idx--;
          if (cal_idx >= 0) r.beep = BEEP_STEP;
          if (cal_idx == -1) begin
            r.beep = BEEP_END;
            cal_left = END_DELAY;
          end
          if (cal_idx <= -2) begin
            cal_idx = -2;
            cal_run = 1'b0;
            r.save = 1'b1;
          end
        end
      end
    end
    r.mute = mute_st;
    r.active = cal_run;
    return r;
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      err_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    tick_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (tick_results_q.size() == 0) begin
        $error("unexpected result transaction: m_tdata %h", m_tdata);
        err_count++;
      end else begin
        want = tick_results_q.pop_front();
        check_field("mute_state", want.mute, m_tdata[OUT_MUTE_LSB +: 3]);
        check_field("beep_code", want.beep, m_tdata[OUT_BEEP_LSB +: 2]);
        check_field("capture_valid", want.cap_valid, m_tdata[OUT_CAPV_BIT]);
        check_field("capture_cm", want.cap_cm, m_tdata[OUT_CM_LSB +: 5]);
        check_field("capture_value", want.cap_value, m_tdata[OUT_VALUE_LSB +: 32]);
        check_field("save_and_unmute", want.save, m_tdata[OUT_SAVE_BIT]);
        check_field("calibration_active", want.active, m_tdata[OUT_ACTIVE_BIT]);
      end
    end
  end

  // one input transaction, with an occasional idle gap in front
  task automatic drive_tick(input logic cmd, input logic [15:0] pitch,
                            input logic [23:0] vol, input logic [31:0] period);
    if (!no_idle && $urandom_range(99) < 11) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 11);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {period, vol, pitch};
    do @(posedge clk); while (!s_tready);
    tick_results_q.push_back(predict_tick_result(cmd, pitch, vol, period));
  endtask

  // pitch and volume biased toward the thresholds, so the mute machine moves
  task automatic drive_random_tick(input bit allow_start);
    logic        c;
    logic [15:0] p;
    logic [23:0] v;
    case ($urandom_range(7))
      0: p = 16'd0;
      1: p = cfg_low;
      2: p = cfg_low + 16'd1;
      3: p = cfg_low - 16'd1;
      4: p = cfg_high;
      5: p = cfg_high + 16'd1;
      6: p = 16'hffff;
      default: p = 16'($urandom_range(16'hffff));
    endcase
    case ($urandom_range(9)) inside
      [0:2]: v = 24'd0;
      3: v = 24'($urandom_range(1, 200));
      4: v = {1'b0, cfg_thr};
      5: v = {1'b0, cfg_thr} + 24'd1;
      6: v = -$signed(24'($urandom_range(1, 24'h7fffff)));
      7: v = $urandom_range(1) ? 24'h7fffff : 24'h800000;
      default: v = 24'($urandom);
    endcase
    c = allow_start && ($urandom_range(59) == 0);
    drive_tick(c, p, v, $urandom);
  endtask

  // wait until every result is back and the pipeline is empty
  task automatic drain_results;
    s_tvalid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [22:0] val);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      CFG_AUTOMUTE_EN:  cfg_automute = val[0];
      CFG_AUTOPREHEAR:  cfg_prehear = val[0];
      CFG_LOW_PITCH:    cfg_low = val[15:0];
      CFG_HIGH_PITCH:   cfg_high = val[15:0];
      CFG_PREHEAR_LOUD: cfg_thr = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic am, input logic ph, input logic [15:0] low,
                                input logic [15:0] high, input logic [22:0] thr);
    drain_results();
    write_reg(CFG_AUTOMUTE_EN, {22'd0, am});
    write_reg(CFG_AUTOPREHEAR, {22'd0, ph});
    write_reg(CFG_LOW_PITCH, {7'd0, low});
    write_reg(CFG_HIGH_PITCH, {7'd0, high});
    write_reg(CFG_PREHEAR_LOUD, thr);
  endtask

  // walk every mute transition, field extremes, start and restart
  task automatic test_directed;
    // auto-mute off after reset: forced loud
    drive_tick(1'b0, 16'hffff, 24'h800000, 32'hffffffff);
    drive_tick(1'b0, 16'h0000, 24'h7fffff, 32'h00000000);
    apply_settings(1'b1, 1'b1, RST_LOW_PITCH, RST_HIGH_PITCH, RST_PREHEAR_LOUD);
    drive_tick(1'b0, 16'd0, 24'd0, 32'h1);
    drive_tick(1'b0, 16'd328, 24'd0, 32'h2);
    drive_tick(1'b0, 16'd329, 24'd0, 32'h3);
    drive_tick(1'b0, 16'hffff, 24'd0, 32'h4);
    drive_tick(1'b0, 16'hffff, 24'd100, 32'h5);
    drive_tick(1'b0, 16'hffff, 24'hffffff, 32'h6);
    drive_tick(1'b0, 16'd1000, 24'd101, 32'h7);
    drive_tick(1'b0, 16'd1000, 24'd5, 32'h8);
    drive_tick(1'b0, 16'd1000, 24'd0, 32'h9);
    drive_tick(1'b0, 16'd0, 24'd0, 32'ha);
    drive_tick(1'b0, 16'd400, 24'd0, 32'hb);
    drive_tick(1'b0, 16'd400, 24'd1, 32'hc);
    // start, then restart while running
    drive_tick(1'b1, 16'hffff, 24'hffffff, 32'hdeadbeef);
    drive_tick(1'b0, 16'd0, 24'd0, 32'h0);
    drive_tick(1'b1, 16'd0, 24'd0, 32'h0);
    drive_tick(1'b0, 16'd500, 24'd3, 32'h55555555);
    drive_tick(1'b0, 16'd0, 24'd0, 32'haaaaaaaa);
    // prehear disabled: ready holds on a high pitch
    apply_settings(1'b1, 1'b0, RST_LOW_PITCH, RST_HIGH_PITCH, RST_PREHEAR_LOUD);
    drive_tick(1'b0, 16'd400, 24'd0, 32'h0);
    drive_tick(1'b0, 16'hffff, 24'd0, 32'h0);
    drive_tick(1'b0, 16'd400, 24'hfffffb, 32'h0);
  endtask

  // random ticks across several register settings
  task automatic test_random_settings;
    apply_settings(1'b1, 1'b1, RST_LOW_PITCH, RST_HIGH_PITCH, RST_PREHEAR_LOUD);
    repeat (100) drive_random_tick(1'b1);
    apply_settings(1'b1, 1'b0, 16'd0, 16'd0, 23'd0);
    repeat (100) drive_random_tick(1'b1);
    apply_settings(1'b1, 1'b1, 16'hffff, 16'hffff, 23'h7fffff);
    no_idle = 1'b1;
    repeat (100) drive_random_tick(1'b1);
    no_idle = 1'b0;
    apply_settings(1'b0, 1'b1, 16'($urandom), 16'($urandom), 23'($urandom));
    repeat (100) drive_random_tick(1'b1);
    repeat (2) begin
      apply_settings(1'b1, 1'b1, 16'($urandom_range(2000)),
                     16'($urandom_range(1000, 65535)), 23'($urandom_range(500)));
      repeat (100) drive_random_tick(1'b1);
    end
  endtask

  // full calibration: restart after the first capture, then run to the save pulse
  task automatic test_calibration;
    apply_settings(1'b1, 1'b1, RST_LOW_PITCH, RST_HIGH_PITCH, RST_PREHEAR_LOUD);
    drive_tick(1'b1, 16'd0, 24'd0, $urandom);
    no_idle = 1'b1;
    repeat (START_DELAY + STEP_DELAY / 4) drive_random_tick(1'b0);
    no_idle = 1'b0;
    drive_tick(1'b1, 16'($urandom), 24'($urandom), $urandom);
    while (cal_run) drive_random_tick(1'b0);
    repeat (10) drive_random_tick(1'b0);
  endtask

  initial begin
    cfg_automute = 1'b0;
    cfg_prehear = 1'b0;
    cfg_low = RST_LOW_PITCH;
    cfg_high = RST_HIGH_PITCH;
    cfg_thr = RST_PREHEAR_LOUD;
    mute_st = ST_MUTE;
    cal_run = 1'b0;
    cal_left = 0;
    cal_idx = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_settings();
    test_calibration();
    drain_results();
    repeat (5) @(posedge clk);
    if (err_count == 0 && tick_results_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/vmct_pkg.sv
rtl/volume_mute_and_calibration_tick_top.sv
rtl/vmct_checker.sv
tb/volume_mute_and_calibration_tick_top_tb.sv
